FILE: sv/wss_pkg.sv
// Shared constants, types and a helper function of the wildcard signature scanner.
package wss_pkg;

  localparam int unsigned WINDOW_BYTES = 32;
  localparam int unsigned PATTERN_MAX  = 16;
  localparam int unsigned JOB_DEPTH    = 2;

  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned LEN_REG_W    = 5;
  localparam int unsigned OFFSET_W     = 5;
  localparam int unsigned MODE_W       = 2;

  // Bytes in a little-endian word, and the length of a relative call instruction.
  localparam int unsigned WORD_BYTES   = 4;
  localparam int unsigned CALL_LEN     = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_EXTRACT_OFS  = 3'd3,
    REG_EXTRACT_MODE = 3'd4,
    REG_BASE_ADDR    = 3'd5
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_WORD = 2'd0,
    MODE_ADDR = 2'd1,
    MODE_CALL = 2'd2
  } extract_mode_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_low_bytes;
    logic [CFG_DATA_W-1:0] pattern_high_bytes;
    logic [LEN_REG_W-1:0]  pattern_length;
    logic [OFFSET_W-1:0]   extract_offset;
    logic [MODE_W-1:0]     extract_mode;
    logic [WORD_W-1:0]     base_address;
  } cfg_t;

  typedef struct packed {
    logic              end_of_region;
    logic [WORD_W-1:0] bytes_seen;
  } job_meta_t;

  // Pattern byte i, byte 0 in the low bits of the low register.
  function automatic logic [7:0] pattern_byte(input logic [CFG_DATA_W-1:0] lo,
                                              input logic [CFG_DATA_W-1:0] hi,
                                              input int unsigned i);
    logic [7:0] b;
    if (i < 8) begin
      b = lo[8*i +: 8];
    end else begin
      b = hi[8*(i-8) +: 8];
    end
    return b;
  endfunction

endpackage

FILE: sv/wss_ifs.sv
// Valid/ready channel interfaces for bytes in, results out and configuration writes.
interface wss_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_region;

  modport source (output valid, output data_byte, output end_of_region, input ready);
  modport sink   (input valid, input data_byte, input end_of_region, output ready);
endinterface

interface wss_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] match_address;
  logic [31:0] extracted_value;
  logic        beyond_region;
  logic        last_of_run;

  modport source (output valid, output result_kind, output match_address,
                  output extracted_value, output beyond_region, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input match_address,
                  input extracted_value, input beyond_region, input last_of_run,
                  output ready);
endinterface

interface wss_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [63:0] write_data;

  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

FILE: sv/wss_front.sv
// Front end: byte window shift line, region counters and job generation.
module wss_front #(
  parameter int unsigned WindowBytes = wss_pkg::WINDOW_BYTES,
  localparam int unsigned FillW = $clog2(WindowBytes + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         end_of_region_i,
  output logic                         push_o,
  input  logic                         push_ready_i,
  output logic [WindowBytes-1:0][7:0]  push_win_o,
  output logic [FillW-1:0]             push_fill_o,
  output wss_pkg::job_meta_t           push_meta_o
);
  import wss_pkg::*;

  logic [WindowBytes-1:0][7:0] win_q, win_d;
  logic [FillW-1:0]            fill_q, fill_d, fill_inc;
  logic [WORD_W-1:0]           seen_q, seen_d, seen_inc;
  logic                        accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;

  always_comb begin
    // Entry 0 holds the newest byte.
    win_d    = {win_q[WindowBytes-2:0], data_byte_i};
    fill_inc = (fill_q == FillW'(WindowBytes)) ? fill_q : fill_q + 1'b1;
    seen_inc = seen_q + 1'b1;
    fill_d   = fill_q;
    seen_d   = seen_q;
    if (accept) begin
      fill_d = end_of_region_i ? '0 : fill_inc;
      seen_d = end_of_region_i ? '0 : seen_inc;
    end
  end

  assign push_o      = accept;
  assign push_win_o  = win_d;
  assign push_fill_o = fill_inc;
  assign push_meta_o = '{end_of_region: end_of_region_i, bytes_seen: seen_inc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      seen_q <= '0;
    end else begin
      fill_q <= fill_d;
      seen_q <= seen_d;
    end
  end

  // Stale bytes beyond the fill count are never looked at.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

endmodule

FILE: sv/wss_job_fifo.sv
// Short job queue between the front end and the match engine.
module wss_job_fifo #(
  parameter int unsigned WindowBytes = wss_pkg::WINDOW_BYTES,
  parameter int unsigned Depth       = wss_pkg::JOB_DEPTH,
  localparam int unsigned FillW = $clog2(WindowBytes + 1),
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         push_ready_o,
  input  logic [WindowBytes-1:0][7:0]  push_win_i,
  input  logic [FillW-1:0]             push_fill_i,
  input  wss_pkg::job_meta_t           push_meta_i,
  output logic                         head_valid_o,
  input  logic                         pop_i,
  output logic [WindowBytes-1:0][7:0]  head_win_o,
  output logic [FillW-1:0]             head_fill_o,
  output wss_pkg::job_meta_t           head_meta_o
);
  import wss_pkg::*;

  logic [WindowBytes-1:0][7:0] win_q  [Depth];
  logic [FillW-1:0]            fill_q [Depth];
  job_meta_t                   meta_q [Depth];
  logic [PtrW-1:0]             wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]             count_q, count_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready_o = (count_q != CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_win_o   = win_q[rd_ptr_q];
  assign head_fill_o  = fill_q[rd_ptr_q];
  assign head_meta_o  = meta_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      win_q[wr_ptr_q]  <= push_win_i;
      fill_q[wr_ptr_q] <= push_fill_i;
      meta_q[wr_ptr_q] <= push_meta_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != CntW'(Depth))
    else $error("job queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("job queue read while empty");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)
    else $error("job queue count lost a write");

endmodule

FILE: sv/wss_back.sv
// Match engine: walks start positions of a job, checks the pattern and builds results.
module wss_back #(
  parameter int unsigned WindowBytes = wss_pkg::WINDOW_BYTES,
  parameter int unsigned PatternMax  = wss_pkg::PATTERN_MAX,
  localparam int unsigned FillW = $clog2(WindowBytes + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wss_pkg::cfg_t                cfg_i,
  input  logic                         head_valid_i,
  input  logic [WindowBytes-1:0][7:0]  head_win_i,
  input  logic [FillW-1:0]             head_fill_i,
  input  wss_pkg::job_meta_t           head_meta_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         result_kind_o,
  output logic [31:0]                  match_address_o,
  output logic [31:0]                  extracted_value_o,
  output logic                         beyond_region_o,
  output logic                         last_of_run_o
);
  import wss_pkg::*;

  localparam int unsigned IdxW = $clog2(WindowBytes);
  localparam int unsigned SW   = FillW + 2;
  localparam int unsigned LenW = $clog2(PatternMax + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} seq_state_e;

  typedef struct packed {
    logic              done;
    logic              last;
    logic              match;
    logic              beyond;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] seen_minus_d;
  } s1_t;

  typedef struct packed {
    logic              done;
    logic              last;
    logic              beyond;
    logic              add_addr;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] partial;
  } s2_t;

  typedef struct packed {
    logic              done;
    logic              last;
    logic              beyond;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] value;
  } s3_t;

  // Effective pattern length and number of bytes a position needs.
  logic [LenW-1:0]  len_eff;
  logic [SW-1:0]    ext_span, need_span;
  logic [FillW-1:0] need, start;

  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len_eff = LenW'(1);
    end else if (cfg_i.pattern_length > LEN_REG_W'(PatternMax)) begin
      len_eff = LenW'(PatternMax);
    end else begin
      len_eff = LenW'(cfg_i.pattern_length);
    end
    unique case (cfg_i.extract_mode)
      MODE_WORD: ext_span = SW'(cfg_i.extract_offset) + SW'(WORD_BYTES);
      MODE_CALL: ext_span = SW'(cfg_i.extract_offset) + SW'(CALL_LEN);
      default:   ext_span = '0;
    endcase
    need_span = (ext_span > SW'(len_eff)) ? ext_span : SW'(len_eff);
    if (need_span > SW'(WindowBytes)) begin
      need_span = SW'(WindowBytes);
    end
    need  = FillW'(need_span);
    start = (head_fill_i >= need) ? need : head_fill_i;
  end

  // Sequencer.
  seq_state_e       state_q, state_d;
  logic [FillW-1:0] d_q, d_d;
  logic             iss_valid, iss_done, iss_last;
  logic [FillW-1:0] iss_d;
  logic             s1_ready, s2_ready, s3_ready;

  always_comb begin
    state_d   = state_q;
    d_d       = d_q;
    iss_valid = 1'b0;
    iss_done  = 1'b0;
    iss_last  = 1'b0;
    iss_d     = need;
    pop_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          if (!head_meta_i.end_of_region) begin
            iss_valid = (head_fill_i >= need);
            iss_last  = 1'b1;
            pop_o     = !iss_valid || s1_ready;
          end else begin
            d_d     = start;
            state_d = (start >= FillW'(len_eff)) ? ST_SCAN : ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        iss_valid = 1'b1;
        iss_d     = d_q;
        if (s1_ready) begin
          if (d_q <= FillW'(len_eff)) begin
            state_d = ST_DONE;
          end else begin
            d_d = d_q - 1'b1;
          end
        end
      end
      ST_DONE: begin
        iss_valid = 1'b1;
        iss_done  = 1'b1;
        iss_last  = 1'b1;
        iss_d     = '0;
        if (s1_ready) begin
          pop_o   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      d_q     <= '0;
    end else begin
      state_q <= state_d;
      d_q     <= d_d;
    end
  end

  // Position check: every pattern lane compares against the window in parallel.
  logic [PatternMax-1:0][7:0]    pat_b;
  logic [PatternMax-1:0][SW-1:0] pat_idx;
  logic [PatternMax-1:0]         lane_ok;
  logic [SW-1:0]                 ext_base;
  logic [WORD_BYTES-1:0][SW-1:0] ext_dist, ext_idx;
  logic [WORD_BYTES-1:0]         ext_ok;
  logic [WORD_W-1:0]             iss_word;
  logic                          uses_word;
  s1_t                           iss_s1;

  always_comb begin
    for (int i = 0; i < PatternMax; i++) begin
      pat_b[i]   = pattern_byte(cfg_i.pattern_low_bytes, cfg_i.pattern_high_bytes, i);
      pat_idx[i] = SW'(iss_d) - SW'(i) - SW'(1);
      lane_ok[i] = (LenW'(i) >= len_eff) || (pat_b[i] == '0) ||
                   (!pat_idx[i][SW-1] && (head_win_i[pat_idx[i][IdxW-1:0]] == pat_b[i]));
    end
    // The call target reads its rel32 one byte after the opcode.
    ext_base = SW'(iss_d) - SW'(cfg_i.extract_offset) -
               ((cfg_i.extract_mode == MODE_CALL) ? SW'(1) : SW'(0));
    for (int k = 0; k < WORD_BYTES; k++) begin
      ext_dist[k]        = ext_base - SW'(k);
      ext_idx[k]         = ext_dist[k] - SW'(1);
      ext_ok[k]          = !ext_dist[k][SW-1] && (ext_dist[k] != '0);
      iss_word[8*k +: 8] = ext_ok[k] ? head_win_i[ext_idx[k][IdxW-1:0]] : 8'h00;
    end
    uses_word = !iss_done && ((cfg_i.extract_mode == MODE_WORD) ||
                              (cfg_i.extract_mode == MODE_CALL));
    iss_s1.done         = iss_done;
    iss_s1.last         = iss_last;
    iss_s1.match        = iss_done || (&lane_ok);
    iss_s1.beyond       = uses_word && !(&ext_ok);
    iss_s1.word         = iss_word;
    iss_s1.seen_minus_d = head_meta_i.bytes_seen - WORD_W'(iss_d);
  end

  // Three register stages: check, address and partial sum, final sum.
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  s1_t  s1_q;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;

  assign s3_ready = !s3_valid_q || out_ready_i;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;

  always_comb begin
    s2_d.done     = s1_q.done;
    s2_d.last     = s1_q.last;
    s2_d.beyond   = s1_q.beyond;
    s2_d.addr     = cfg_i.base_address + s1_q.seen_minus_d;
    s2_d.add_addr = !s1_q.done && ((cfg_i.extract_mode == MODE_ADDR) ||
                                   (cfg_i.extract_mode == MODE_CALL));
    if (s1_q.done) begin
      s2_d.partial = '0;
    end else begin
      case (cfg_i.extract_mode)
        MODE_WORD: s2_d.partial = s1_q.word;
        MODE_ADDR: s2_d.partial = WORD_W'(cfg_i.extract_offset);
        MODE_CALL: s2_d.partial = s1_q.word + WORD_W'(cfg_i.extract_offset) +
                                  WORD_W'(CALL_LEN);
        default:   s2_d.partial = '0;
      endcase
    end
    s3_d.done   = s2_q.done;
    s3_d.last   = s2_q.last;
    s3_d.beyond = s2_q.beyond;
    s3_d.addr   = s2_q.addr;
    s3_d.value  = s2_q.add_addr ? s2_q.addr + s2_q.partial : s2_q.partial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= iss_valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q && s1_q.match;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && iss_valid) begin
      s1_q <= iss_s1;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
    if (s3_ready && s2_valid_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o       = s3_valid_q;
  assign result_kind_o     = s3_q.done;
  assign match_address_o   = s3_q.addr;
  assign extracted_value_o = s3_q.value;
  assign beyond_region_o   = s3_q.beyond;
  assign last_of_run_o     = s3_q.last;

  a_scan_position_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> d_q != '0)
    else $error("scan walked below the first start position");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && s3_q.done |-> s3_q.last)
    else $error("done result not marked as last of its run");

  a_check_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_q))
    else $error("check stage lost its contents under stall");

  a_end_job_retired_by_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_meta_i.end_of_region |-> state_q == ST_DONE)
    else $error("end of region request retired before its done result");

endmodule

FILE: sv/wildcard_signature_scanner_unit.sv
// Top level of the wildcard signature scanner: configuration registers and block wiring.
//
// The byte channel takes one request per region byte, end_of_region set on the final one.
// Every start position where the pattern matches (zero pattern bytes match anything)
// yields one result request on the result channel, overlapping matches included, carrying
// the match address and the value picked by the extract mode. The final byte of a region
// first flushes every position still pending and then yields a done result whose
// match_address is the base address plus the region length.
// The configuration channel is always ready; register i of the list is written by index i.
// The user must write only while no request is in flight; the block does not enforce it.
// Throughput is one byte per cycle while the job queue has room. A byte's job passes through
// the job queue and the check, address and final sum stages; the last is the output register.
// The final byte of a region holds the match engine for its flush: a setup step, a check of
// each pending position (at most the window span less the pattern length plus one) and the
// done result; bytes of the next region queue up behind it in the two-entry job queue.
// Reset restores the register defaults and an empty window; no clearing pass is needed.
// When the receiver stalls, the three engine stages and the job queue fill up and then
// the byte channel drops ready; nothing is lost or repeated.
module wildcard_signature_scanner_unit #(
  parameter int unsigned WindowBytes = wss_pkg::WINDOW_BYTES,
  parameter int unsigned PatternMax  = wss_pkg::PATTERN_MAX,
  parameter int unsigned JobDepth    = wss_pkg::JOB_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  wss_byte_if.sink        byte_i,
  wss_result_if.source    result_o,
  wss_cfg_if.sink         cfg_i
);
  import wss_pkg::*;

  localparam int unsigned FillW = $clog2(WindowBytes + 1);

  // Configuration registers. Writes to indexes past the list are dropped.
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_low_bytes  <= '0;
      cfg_q.pattern_high_bytes <= '0;
      cfg_q.pattern_length     <= LEN_REG_W'(1);
      cfg_q.extract_offset     <= '0;
      cfg_q.extract_mode       <= MODE_WORD;
      cfg_q.base_address       <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_PATTERN_LOW:  cfg_q.pattern_low_bytes  <= cfg_i.write_data;
        REG_PATTERN_HIGH: cfg_q.pattern_high_bytes <= cfg_i.write_data;
        REG_PATTERN_LEN:  cfg_q.pattern_length     <= cfg_i.write_data[LEN_REG_W-1:0];
        REG_EXTRACT_OFS:  cfg_q.extract_offset     <= cfg_i.write_data[OFFSET_W-1:0];
        REG_EXTRACT_MODE: cfg_q.extract_mode       <= cfg_i.write_data[MODE_W-1:0];
        REG_BASE_ADDR:    cfg_q.base_address       <= cfg_i.write_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end to job queue.
  logic                        push, push_ready;
  logic [WindowBytes-1:0][7:0] push_win;
  logic [FillW-1:0]            push_fill;
  job_meta_t                   push_meta;

  // Job queue to match engine.
  logic                        head_valid, pop;
  logic [WindowBytes-1:0][7:0] head_win;
  logic [FillW-1:0]            head_fill;
  job_meta_t                   head_meta;

  wss_front #(
    .WindowBytes (WindowBytes)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (byte_i.valid),
    .in_ready_o      (byte_i.ready),
    .data_byte_i     (byte_i.data_byte),
    .end_of_region_i (byte_i.end_of_region),
    .push_o          (push),
    .push_ready_i    (push_ready),
    .push_win_o      (push_win),
    .push_fill_o     (push_fill),
    .push_meta_o     (push_meta)
  );

  wss_job_fifo #(
    .WindowBytes (WindowBytes),
    .Depth       (JobDepth)
  ) u_job_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_win_i   (push_win),
    .push_fill_i  (push_fill),
    .push_meta_i  (push_meta),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_win_o   (head_win),
    .head_fill_o  (head_fill),
    .head_meta_o  (head_meta)
  );

  wss_back #(
    .WindowBytes (WindowBytes),
    .PatternMax  (PatternMax)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .head_valid_i      (head_valid),
    .head_win_i        (head_win),
    .head_fill_i       (head_fill),
    .head_meta_i       (head_meta),
    .pop_o             (pop),
    .out_valid_o       (result_o.valid),
    .out_ready_i       (result_o.ready),
    .result_kind_o     (result_o.result_kind),
    .match_address_o   (result_o.match_address),
    .extracted_value_o (result_o.extracted_value),
    .beyond_region_o   (result_o.beyond_region),
    .last_of_run_o     (result_o.last_of_run)
  );

endmodule
